// ===== src/tdt_pkg.sv =====
package tdt_pkg;

    localparam int TIME_W       = 64;
    localparam int REQ_W        = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 72;
    localparam int M_PAD_W      = M_TDATA_W - TIME_W - 2;

    localparam logic [CFG_DATA_W-1:0] PERIODIC_RELOAD_RST = 24'd19999;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_READ    = 3'd1,
        REQ_ARM     = 3'd2,
        REQ_DISARM  = 3'd3,
        REQ_SET     = 3'd4,
        REQ_IRQ_ON  = 3'd5,
        REQ_IRQ_OFF = 3'd6
    } req_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 1'b0,
        CFG_RELOAD = 1'b1
    } cfg_idx_t;

endpackage

// ===== src/tdt_interval_calc.sv =====
module tdt_interval_calc import tdt_pkg::*; #(
    parameter int COUNTER_BITS = 24
) (
    input  logic [TIME_W-1:0]       armed_time,
    input  logic [TIME_W-1:0]       from_time,
    input  logic                    armed_ok,
    output logic                    later,
    output logic [COUNTER_BITS-1:0] reload
);

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] gap;

    // armed + ~from = armed - from - 1, carry set when armed > from
    assign sum   = {1'b0, armed_time} + {1'b0, ~from_time};
    assign later = sum[TIME_W];
    assign gap   = sum[TIME_W-1:0];

    always_comb begin
        if (!armed_ok) begin
            reload = '1;
        end else if (!later) begin
            reload = '0;
        end else if (|gap[TIME_W-1:COUNTER_BITS]) begin
            reload = '1;
        end else begin
            reload = gap[COUNTER_BITS-1:0];
        end
    end

endmodule

// ===== src/tickless_deadline_timer_core.sv =====
// OS time base on a COUNTER_BITS down counter with periodic and tickless modes and one
// deadline. Each request beat on the slave side yields exactly one result beat holding the
// time after the request, the interrupt flag and the error flag. The block takes one beat
// per clock while the result register is not held by m_axis_tready; a result beat passes
// the input register, then the result register, before it is presented on the master side.
// The result register lets one more request be taken while a result waits on m_axis_tready.
// All state updates for a request happen at the edge that loads its result register, so
// back-to-back requests see each other's effects.
// Configuration writes are taken at any time but must only be issued while no request is
// in flight; a write to the mode register restarts the timer in that mode.
module tickless_deadline_timer_core import tdt_pkg::*; #(
    parameter int COUNTER_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [63:0] value
    input  logic [REQ_W-1:0]       s_axis_tuser,   // [2:0] req_type

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // [63:0] time_now, [64] irq, [65] error

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [31:0] RELOAD_MAX_W = 32'((64'd1 << COUNTER_BITS) - 64'd1);

    logic                    s1_valid_reg;
    req_t                    s1_req_reg;
    logic [TIME_W-1:0]       s1_value_reg;

    logic                    mode_reg;
    logic [CFG_DATA_W-1:0]   preload_reg;

    logic [COUNTER_BITS-1:0] down_reg, down_next;
    logic [COUNTER_BITS-1:0] interval_reg, interval_next;
    logic [TIME_W-1:0]       base_reg, base_next;
    logic [TIME_W-1:0]       cur_reg, cur_next;
    logic [TIME_W-1:0]       cur_inc_reg, cur_inc_next;
    logic [TIME_W-1:0]       armed_reg, armed_next;
    logic                    armed_valid_reg, armed_valid_next;
    logic                    delivery_reg, delivery_next;

    logic                    m_valid_reg;
    logic [TIME_W-1:0]       m_time_reg;
    logic                    m_irq_reg, m_err_reg;

    logic                    advance;
    logic                    cfg_fire;
    logic                    irq_next, err_next;
    logic                    wrap;
    logic [31:0]             pr_wide;
    logic [COUNTER_BITS-1:0] periodic_ld;
    logic                    arm_take;
    logic [TIME_W-1:0]       armed_new;
    logic [TIME_W:0]         end_diff;
    logic                    before_end;
    logic                    reached;
    logic [COUNTER_BITS-1:0] tick_reload;

    logic [TIME_W-1:0]       calc_armed, calc_from;
    logic                    calc_ok, calc_later;
    logic [COUNTER_BITS-1:0] calc_reload;

    assign advance       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_err_reg, m_irq_reg, m_time_reg};

    // periodic reload, with zero read as one and oversize read as full period
    assign pr_wide = 32'(preload_reg);
    always_comb begin
        if (preload_reg == '0) begin
            periodic_ld = COUNTER_BITS'(1);
        end else if (pr_wide > RELOAD_MAX_W) begin
            periodic_ld = '1;
        end else begin
            periodic_ld = COUNTER_BITS'(pr_wide);
        end
    end

    assign wrap      = (down_reg == '0);
    assign arm_take  = !armed_valid_reg || (s1_value_reg < armed_reg);
    assign armed_new = arm_take ? s1_value_reg : armed_reg;

    // deadline falls at or before the end of the running interval
    assign end_diff   = {1'b0, armed_new} - {1'b0, base_reg};
    assign before_end = end_diff[TIME_W] ||
                        (end_diff[TIME_W-1:0] <= TIME_W'(interval_reg));

    always_comb begin
        unique case (s1_req_reg)
            REQ_ARM: begin
                calc_armed = armed_new;
                calc_from  = cur_reg;
                calc_ok    = 1'b1;
            end
            REQ_SET: begin
                calc_armed = armed_reg;
                calc_from  = s1_value_reg;
                calc_ok    = armed_valid_reg;
            end
            default: begin
                calc_armed = armed_reg;
                calc_from  = cur_inc_reg;
                calc_ok    = armed_valid_reg;
            end
        endcase
    end

    tdt_interval_calc #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_calc (
        .armed_time (calc_armed),
        .from_time  (calc_from),
        .armed_ok   (calc_ok),
        .later      (calc_later),
        .reload     (calc_reload)
    );

    assign reached     = armed_valid_reg && !calc_later;
    assign tick_reload = reached ? '1 : calc_reload;

    always_comb begin
        down_next        = down_reg;
        interval_next    = interval_reg;
        base_next        = base_reg;
        cur_next         = cur_reg;
        cur_inc_next     = cur_inc_reg;
        armed_next       = armed_reg;
        armed_valid_next = armed_valid_reg;
        delivery_next    = delivery_reg;
        irq_next         = 1'b0;
        err_next         = 1'b0;
        unique case (s1_req_reg)
            REQ_TICK: begin
                if (!wrap) begin
                    down_next = down_reg - COUNTER_BITS'(1);
                    if (mode_reg) begin
                        cur_next     = cur_inc_reg;
                        cur_inc_next = cur_inc_reg + TIME_W'(1);
                    end
                end else if (!mode_reg) begin
                    cur_next      = cur_inc_reg;
                    cur_inc_next  = cur_inc_reg + TIME_W'(1);
                    interval_next = periodic_ld;
                    down_next     = periodic_ld;
                    irq_next      = delivery_reg;
                end else begin
                    base_next     = cur_inc_reg;
                    cur_next      = cur_inc_reg;
                    cur_inc_next  = cur_inc_reg + TIME_W'(1);
                    interval_next = tick_reload;
                    down_next     = tick_reload;
                    irq_next      = reached && delivery_reg;
                    if (reached) begin
                        armed_valid_next = 1'b0;
                    end
                end
            end
            REQ_ARM: begin
                if (mode_reg) begin
                    armed_next       = armed_new;
                    armed_valid_next = 1'b1;
                    if (before_end) begin
                        base_next     = cur_reg;
                        interval_next = calc_reload;
                        down_next     = calc_reload;
                    end
                end else begin
                    err_next = 1'b1;
                end
            end
            REQ_DISARM: begin
                if (mode_reg) begin
                    armed_valid_next = 1'b0;
                end else begin
                    err_next = 1'b1;
                end
            end
            REQ_SET: begin
                cur_next     = s1_value_reg;
                cur_inc_next = s1_value_reg + TIME_W'(1);
                if (mode_reg) begin
                    base_next     = s1_value_reg;
                    interval_next = calc_reload;
                    down_next     = calc_reload;
                end
            end
            REQ_IRQ_ON:  delivery_next = 1'b1;
            REQ_IRQ_OFF: delivery_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            mode_reg        <= 1'b1;
            preload_reg     <= PERIODIC_RELOAD_RST;
            down_reg        <= '1;
            interval_reg    <= '1;
            base_reg        <= '0;
            cur_reg         <= '0;
            cur_inc_reg     <= TIME_W'(1);
            armed_reg       <= '1;
            armed_valid_reg <= 1'b0;
            delivery_reg    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            priority if (cfg_fire && cfg_idx_t'(cfg_index) == CFG_MODE) begin
                mode_reg        <= cfg_data[0];
                base_reg        <= '0;
                cur_reg         <= '0;
                cur_inc_reg     <= TIME_W'(1);
                armed_reg       <= '1;
                armed_valid_reg <= 1'b0;
                delivery_reg    <= 1'b0;
                interval_reg    <= cfg_data[0] ? '1 : periodic_ld;
                down_reg        <= cfg_data[0] ? '1 : periodic_ld;
            end else if (cfg_fire && cfg_idx_t'(cfg_index) == CFG_RELOAD) begin
                preload_reg <= cfg_data;
            end else if (advance) begin
                down_reg        <= down_next;
                interval_reg    <= interval_next;
                base_reg        <= base_next;
                cur_reg         <= cur_next;
                cur_inc_reg     <= cur_inc_next;
                armed_reg       <= armed_next;
                armed_valid_reg <= armed_valid_next;
                delivery_reg    <= delivery_next;
            end else begin
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            s1_req_reg   <= req_t'(s_axis_tuser);
            s1_value_reg <= s_axis_tdata;
        end
        if (advance) begin
            m_time_reg <= cur_next;
            m_irq_reg  <= irq_next;
            m_err_reg  <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_down_in_interval: assert property (@(posedge aclk) disable iff (!aresetn)
        down_reg <= interval_reg)
        else $error("down counter above interval reload");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stage is stalled");

    a_tickless_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && advance && !cfg_fire && s1_req_reg == REQ_TICK && mode_reg && !wrap)
        |=> (cur_reg == $past(cur_reg) + TIME_W'(1)))
        else $error("tickless time did not advance on a tick");

    a_inc_tracks_time: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_inc_reg == cur_reg + TIME_W'(1))
        else $error("time increment register out of step");
`endif

endmodule
